// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the RTL frame tracker.
// Each macro wraps a concurrent assertion clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property checked at every rising clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked on the next cycle after the antecedent holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lpfr_pkg.sv =====
package lpfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned INDEX_W  = 9;
  localparam int unsigned SUM_W    = 16;
  localparam int unsigned TICK_W   = 16;

  // Header is two command bytes plus the length byte; checksum adds two more.
  localparam logic [INDEX_W-1:0] LEN_BYTE_IDX  = 9'd2;
  localparam logic [INDEX_W-1:0] MIN_FRAME_LEN = 9'd5;

  localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd100;
  localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

  // Input operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Result kind codes.
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  byte_value;
    logic [INDEX_W-1:0] byte_index;
    logic               is_last;
    logic               checksum_ok;
  } lpfr_result_t;

endpackage

// ===== hdl/length_prefixed_frame_receiver_core.sv =====
// Length-prefixed frame receiver with a 16-bit additive checksum.
// Input channel (in_valid_i/in_ready_o): each transaction is either a received
// byte (operation_i = byte code, rx_byte_i holds it) or one timer tick.
// Output channel (out_valid_o/out_ready_i): one transaction per received byte,
// giving its index in the frame, a last-byte mark and the checksum verdict, plus
// one timeout transaction when a frame is aborted after too many idle ticks.
// Ticks while no frame is in progress produce nothing.
// Configuration channel (cfg_valid_i/cfg_ready_o): writes timeout_ticks; it is
// always ready and should only be written while the receiver is idle.
// An accepted input transaction is held in the input register and, once the frame
// state update has run on it, in the output register.
// Throughput: one input transaction per cycle while the output is not stalled,
// set by the single frame state update between the input and output registers.
// When the downstream stalls, the output register holds its result and the
// input register holds one more item; the input then deasserts ready.
// Reset empties both pipeline registers by clearing their valid bits, clears the
// frame state, and sets the timeout to 100 ticks.
module length_prefixed_frame_receiver_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [lpfr_pkg::BYTE_W-1:0]   rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          kind_o,
  output logic [lpfr_pkg::BYTE_W-1:0]   byte_value_o,
  output logic [lpfr_pkg::INDEX_W-1:0]  byte_index_o,
  output logic                          is_last_o,
  output logic                          checksum_ok_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpfr_pkg::TICK_W-1:0]   cfg_timeout_ticks_i
);
  import lpfr_pkg::*;

  // Input register stage.
  logic              in_valid_q;
  logic              op_q;
  logic [BYTE_W-1:0] byte_q;

  // Output register stage.
  logic         out_valid_q;
  lpfr_result_t out_q;

  logic [TICK_W-1:0] timeout_ticks_q;

  logic         advance;
  logic         res_valid;
  lpfr_result_t res;

  // The input stage moves on whenever the output register is free or being
  // drained this cycle; an item that yields no result moves on the same way.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      op_q   <= operation_i;
      byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_ticks_q <= TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_ticks_q <= cfg_timeout_ticks_i;
    end
  end

  lpfr_frame_tracker u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .op_i            (op_q),
    .byte_i          (byte_q),
    .timeout_ticks_i (timeout_ticks_q),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // The output register is refilled on a step that yields a result and
  // emptied when its transaction completes without a replacement.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_q.kind;
  assign byte_value_o  = out_q.byte_value;
  assign byte_index_o  = out_q.byte_index;
  assign is_last_o     = out_q.is_last;
  assign checksum_ok_o = out_q.checksum_ok;

endmodule

// ===== hdl/lpfr_frame_tracker.sv =====
`include "assert_macros.svh"

module lpfr_frame_tracker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  logic                                op_i,
  input  logic [lpfr_pkg::BYTE_W-1:0]         byte_i,
  input  logic [lpfr_pkg::TICK_W-1:0]         timeout_ticks_i,
  output logic                                res_valid_o,
  output lpfr_pkg::lpfr_result_t              res_o
);
  import lpfr_pkg::*;

  logic [INDEX_W-1:0] byte_count_q, byte_count_d;
  logic [INDEX_W-1:0] expected_total_q, expected_total_d;
  logic [SUM_W-1:0]   running_sum_q, running_sum_d;
  logic [BYTE_W-1:0]  checksum_high_q, checksum_high_d;
  logic [TICK_W-1:0]  idle_ticks_q, idle_ticks_d;

  logic [INDEX_W-1:0] exp_eff;
  logic [INDEX_W:0]   idx_plus2;
  logic [INDEX_W:0]   exp_wide;
  logic [TICK_W-1:0]  idle_inc;
  logic [SUM_W-1:0]   got_sum;
  logic               in_frame;
  logic               timed_out;
  logic               is_sum_byte;
  logic               is_hi_byte;

  assign in_frame  = (byte_count_q != '0);
  assign exp_eff   = (byte_count_q == LEN_BYTE_IDX)
                     ? MIN_FRAME_LEN + INDEX_W'(byte_i) : expected_total_q;
  assign idx_plus2 = {1'b0, byte_count_q} + (INDEX_W+1)'(2);
  assign exp_wide  = {1'b0, exp_eff};
  assign is_sum_byte = (idx_plus2 < exp_wide);
  assign is_hi_byte  = (idx_plus2 == exp_wide);
  assign idle_inc  = (idle_ticks_q == TICK_MAX) ? idle_ticks_q : idle_ticks_q + TICK_W'(1);
  assign timed_out = in_frame && (idle_inc >= timeout_ticks_i);
  assign got_sum   = {checksum_high_q, byte_i};

  always_comb begin
    byte_count_d     = byte_count_q;
    expected_total_d = expected_total_q;
    running_sum_d    = running_sum_q;
    checksum_high_d  = checksum_high_q;
    idle_ticks_d     = idle_ticks_q;
    res_valid_o      = 1'b0;
    res_o            = '0;

    unique case (op_i)
      OP_TICK: begin
        if (in_frame) begin
          if (timed_out) begin
            res_valid_o      = 1'b1;
            res_o.kind       = KIND_TIMEOUT;
            byte_count_d     = '0;
            expected_total_d = MIN_FRAME_LEN;
            running_sum_d    = '0;
            checksum_high_d  = '0;
            idle_ticks_d     = '0;
          end else begin
            idle_ticks_d = idle_inc;
          end
        end
      end
      OP_BYTE: begin
        res_valid_o       = 1'b1;
        res_o.kind        = KIND_BYTE;
        res_o.byte_value  = byte_i;
        res_o.byte_index  = byte_count_q;
        idle_ticks_d      = '0;
        expected_total_d  = exp_eff;
        byte_count_d      = byte_count_q + INDEX_W'(1);
        priority if (is_sum_byte) begin
          running_sum_d = running_sum_q + SUM_W'(byte_i);
        end else if (is_hi_byte) begin
          checksum_high_d = byte_i;
        end else begin
          res_o.is_last     = 1'b1;
          res_o.checksum_ok = (got_sum == running_sum_q);
          byte_count_d      = '0;
          expected_total_d  = MIN_FRAME_LEN;
          running_sum_d     = '0;
          checksum_high_d   = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q     <= '0;
      expected_total_q <= MIN_FRAME_LEN;
      running_sum_q    <= '0;
      checksum_high_q  <= '0;
      idle_ticks_q     <= '0;
    end else if (step_i) begin
      byte_count_q     <= byte_count_d;
      expected_total_q <= expected_total_d;
      running_sum_q    <= running_sum_d;
      checksum_high_q  <= checksum_high_d;
      idle_ticks_q     <= idle_ticks_d;
    end
  end

  // The position inside a frame always stays short of the frame length.
  `ASSERT_PROP(a_count_below_total, byte_count_q < expected_total_q,
               "byte count reached the frame length")
  // Outside a frame the tick counter is kept at zero.
  `ASSERT_PROP(a_idle_clear_outside, (byte_count_q != '0) || (idle_ticks_q == '0),
               "idle ticks counted outside a frame")
  // A timeout or a closing byte leaves the tracker between frames.
  `ASSERT_NEXT(a_frame_closes,
               step_i && res_valid_o && (res_o.is_last || res_o.kind == KIND_TIMEOUT),
               byte_count_q == '0 && expected_total_q == MIN_FRAME_LEN,
               "frame state not cleared after frame end")

endmodule

// ===== tb/length_prefixed_frame_receiver_core_test.sv =====
`timescale 1ns / 1ps

import lpfr_pkg::*;

// Tracks the frame state of the receiver and keeps the results it still owes.
class frame_tracker;
  logic [INDEX_W-1:0] pos;
  logic [INDEX_W-1:0] frame_len;
  logic [SUM_W-1:0]   sum_acc;
  logic [BYTE_W-1:0]  ck_high;
  logic [TICK_W-1:0]  ticks_since_byte;
  logic [TICK_W-1:0]  tick_limit;
  lpfr_result_t       awaited_results[$];
  int                 errors;

  function new();
    tick_limit = TIMEOUT_RESET;
    errors = 0;
    restart_frame();
  endfunction

  function void restart_frame();
    pos = '0;
    frame_len = MIN_FRAME_LEN;
    sum_acc = '0;
    ck_high = '0;
    ticks_since_byte = '0;
  endfunction

  function void set_limit(logic [TICK_W-1:0] v);
    tick_limit = v;
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction

  task report_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  // Work out what one accepted input transaction owes on the output side.
  function void note_rx_item(logic op, logic [BYTE_W-1:0] b);
    lpfr_result_t r;
    logic [INDEX_W-1:0] idx;
    r = '0;
    if (op == OP_TICK) begin
      if (pos == '0) return;
      if (ticks_since_byte != TICK_MAX) ticks_since_byte++;
      if (ticks_since_byte >= tick_limit) begin
        r.kind = KIND_TIMEOUT;
        awaited_results.push_back(r);
        restart_frame();
      end
      return;
    end
    idx = pos;
    ticks_since_byte = '0;
    if (idx == LEN_BYTE_IDX) frame_len = MIN_FRAME_LEN + INDEX_W'(b);
    r.kind = KIND_BYTE;
    r.byte_value = b;
    r.byte_index = idx;
    if (int'(idx) + 2 < int'(frame_len)) begin
      sum_acc = sum_acc + SUM_W'(b);
    end else if (int'(idx) + 2 == int'(frame_len)) begin
      ck_high = b;
    end else begin
      r.is_last = 1'b1;
      r.checksum_ok = ({ck_high, b} == sum_acc);
    end
    awaited_results.push_back(r);
    if (r.is_last) restart_frame();
    else pos = idx + 1'b1;
  endfunction

  task check_rx_result(lpfr_result_t got);
    lpfr_result_t want;
    if (awaited_results.size() == 0) begin
      report_mismatch($sformatf("unexpected result kind=%0d index=%0d", got.kind,
                                got.byte_index));
      return;
    end
    want = awaited_results.pop_front();
    if (got.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
    if (got.byte_value !== want.byte_value)
      report_mismatch($sformatf("byte_value %0h, want %0h", got.byte_value,
                                want.byte_value));
    if (got.byte_index !== want.byte_index)
      report_mismatch($sformatf("byte_index %0d, want %0d", got.byte_index,
                                want.byte_index));
    if (got.is_last !== want.is_last)
      report_mismatch($sformatf("is_last %0d, want %0d", got.is_last, want.is_last));
    if (got.checksum_ok !== want.checksum_ok)
      report_mismatch($sformatf("checksum_ok %0d, want %0d", got.checksum_ok,
                                want.checksum_ok));
  endtask

  task report_leftovers();
    if (awaited_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
  endtask
endclass

module length_prefixed_frame_receiver_core_test;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               operation_i;
  logic [BYTE_W-1:0]  rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               kind_o;
  logic [BYTE_W-1:0]  byte_value_o;
  logic [INDEX_W-1:0] byte_index_o;
  logic               is_last_o;
  logic               checksum_ok_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [TICK_W-1:0]  cfg_timeout_ticks_i;

  frame_tracker       tracker;
  lpfr_result_t       seen;

  // Timeout value that the driver believes is programmed. It decides how many
  // ticks may sit inside a frame and how many are needed to abort one.
  logic [TICK_W-1:0]  cur_timeout;
  int                 bytes_sent;

  // Sender burst control: gaps_on enables idle gaps between bursts.
  bit                 gaps_on;
  int                 burst_left;

  // Receiver stall pattern: a stall starts with odds 1 in stall_odds, and its random
  // length is limited by stall_max. A stall_odds of zero keeps the receiver ready.
  int                 stall_odds;
  int                 stall_max;
  int                 stall_left;

  length_prefixed_frame_receiver_core u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .operation_i         (operation_i),
    .rx_byte_i           (rx_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .kind_o              (kind_o),
    .byte_value_o        (byte_value_o),
    .byte_index_o        (byte_index_o),
    .is_last_o           (is_last_o),
    .checksum_ok_o       (checksum_ok_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_timeout_ticks_i (cfg_timeout_ticks_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // All handshakes are observed at the rising edge, where the inputs driven at
  // the falling edge are stable and the outputs still hold their old values.
  // A result can never belong to an input accepted at the same edge, so the
  // order of the check and the prediction within this block does not matter.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        seen.kind = kind_o;
        seen.byte_value = byte_value_o;
        seen.byte_index = byte_index_o;
        seen.is_last = is_last_o;
        seen.checksum_ok = checksum_ok_o;
        tracker.check_rx_result(seen);
      end
      if (in_valid_i && in_ready_o) tracker.note_rx_item(operation_i, rx_byte_i);
      if (cfg_valid_i && cfg_ready_o) tracker.set_limit(cfg_timeout_ticks_i);
    end
  end

  // Downstream back-pressure. Each stall is a random run of low ready cycles.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, stall_max - 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Offers one input transaction and returns at the edge that accepts it. Valid
  // is left high so that a following call can present the next item directly;
  // a gap between bursts drops valid at one falling edge and raises it again at
  // a later one, never within the same time step.
  task automatic send_item(logic op, logic [BYTE_W-1:0] b);
    @(negedge clk_i);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk_i);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    rx_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic stop_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Waits until every owed result has been taken, then lets the pipeline
  // settle, since a tick still in flight produces nothing to wait for.
  task automatic drain();
    for (int k = 0; k < 50000 && tracker.pending() != 0; k++) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // The timeout register is only written with the input side quiet and every
  // result delivered.
  task automatic write_timeout(logic [TICK_W-1:0] v);
    stop_input();
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_timeout_ticks_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cur_timeout = v;
  endtask

  // Sometimes puts a few ticks before a byte of a frame, always fewer than the
  // timeout so that an open frame survives them.
  task automatic inside_ticks();
    int k;
    if (cur_timeout > 1 && $urandom_range(0, 5) == 0) begin
      k = $urandom_range(1, (cur_timeout > 5) ? 4 : cur_timeout - 1);
      repeat (k) send_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
    end
  endtask

  // Sends a complete frame with n payload bytes. A bad frame carries a checksum
  // with at least one bit wrong. With all_ones set every header and payload byte
  // but the length is 0xFF, which on the longest frame wraps the 16-bit sum.
  task automatic send_frame(int n, bit good, bit all_ones);
    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  ck;
    logic [BYTE_W-1:0] b;
    sum = '0;
    for (int i = 0; i < n + 3; i++) begin
      if (i == 2) b = BYTE_W'(n);
      else if (all_ones) b = 8'hFF;
      else b = BYTE_W'($urandom_range(0, 255));
      inside_ticks();
      send_item(OP_BYTE, b);
      sum = sum + SUM_W'(b);
    end
    ck = good ? sum : sum ^ SUM_W'($urandom_range(1, 65535));
    inside_ticks();
    send_item(OP_BYTE, ck[15:8]);
    inside_ticks();
    send_item(OP_BYTE, ck[7:0]);
    bytes_sent += n + 5;
  endtask

  // Enough ticks to abort whatever frame is open; extra ticks land on an idle
  // receiver and are dropped by it.
  task automatic abort_ticks();
    repeat ((cur_timeout == 0) ? 1 : int'(cur_timeout))
      send_item(OP_TICK, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Opens a frame with a few bytes and then lets it time out.
  task automatic broken_frame();
    int k;
    k = $urandom_range(1, 4);
    repeat (k) send_item(OP_BYTE, BYTE_W'($urandom_range(0, 255)));
    bytes_sent += k;
    abort_ticks();
  endtask

  // A short run of random bytes and ticks, followed by a resynchronizing
  // abort so that the next frame starts from an idle receiver.
  task automatic noise_burst();
    int k;
    logic op;
    k = $urandom_range(1, 6);
    repeat (k) begin
      op = 1'($urandom_range(0, 1));
      send_item(op, BYTE_W'($urandom_range(0, 255)));
      if (op == OP_BYTE) bytes_sent++;
    end
    abort_ticks();
  endtask

  initial begin
    int target;
    int pick;
    tracker = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_BYTE;
    rx_byte_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_timeout_ticks_i = TIMEOUT_RESET;
    cur_timeout = TIMEOUT_RESET;
    bytes_sent = 0;
    gaps_on = 1'b1;
    burst_left = 0;
    stall_odds = 4;
    stall_max = 4;
    stall_left = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset timeout. A tick on an idle receiver must give
    // nothing.
    send_item(OP_TICK, 8'h00);
    // Shortest frame with a good checksum.
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    // One payload byte, ticks inside the frame, and a wrong checksum.
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h01);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'hFF);
    send_item(OP_BYTE, 8'h02);
    send_item(OP_BYTE, 8'hFD);
    // A timeout of one aborts a frame on its first tick.
    write_timeout(16'd1);
    send_item(OP_BYTE, 8'h80);
    send_item(OP_TICK, 8'h00);
    // A zero timeout behaves the same way.
    write_timeout(16'd0);
    send_item(OP_BYTE, 8'h7F);
    send_item(OP_TICK, 8'h00);
    // A received byte clears the tick count, so only the third tick after the
    // second byte aborts.
    write_timeout(16'd3);
    send_item(OP_BYTE, 8'h55);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'hAA);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);

    // Random part in phases, each with its own timeout and idling pattern.
    // Aborts are only provoked with short timeouts, where they cost few ticks.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: write_timeout(TIMEOUT_RESET);
        1: write_timeout(16'd1);
        2: write_timeout(TICK_W'($urandom_range(2, 12)));
        3: write_timeout(TICK_W'($urandom_range(13, 60)));
        4: write_timeout(TICK_MAX);
        default: write_timeout(TICK_W'($urandom_range(2, 6)));
      endcase
      gaps_on = (p != 2);
      stall_odds = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 5 : 2);
      stall_max = (p % 3 == 2) ? 12 : 3;
      if (p == 4) begin
        // Longest frame, which alone makes up this phase.
        send_frame(255, 1'b1, 1'b1);
      end
      target = bytes_sent + ((p == 4) ? 0 : 20);
      while (bytes_sent < target) begin
        pick = $urandom_range(0, 19);
        if (pick < 14 || cur_timeout > 12) begin
          send_frame(($urandom_range(0, 15) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(0, 12),
                     pick < 12 || pick >= 14, 1'b0);
        end else if (pick < 17) begin
          broken_frame();
        end else begin
          noise_burst();
        end
      end
    end

    stop_input();
    drain();
    tracker.report_leftovers();
    if (tracker.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
